### design/pkf_pkg.sv
// Package for the pose Kalman filter: shared constants, register indexes
// and the command struct that the controller sends to the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package pkf_pkg;

  // Number of independent scalar lanes (x, y, z, roll, pitch, yaw).
  localparam int DIMS = 6;
  localparam int LANE_W = $clog2(DIMS);
  localparam int WORD_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd1;

  // One command per cycle from the controller to the datapath.
  typedef struct packed {
    logic              capture;   // latch the incoming measurement word
    logic              load;      // read lane state, form prior and denominator
    logic              div_step;  // one restoring division step
    logic              mul;       // form both gain products
    logic              upd;       // write back estimate and variance
    logic              publish;   // copy estimates into the output register
    logic [LANE_W-1:0] lane;
  } pkf_cmd_t;

endpackage

### design/pkf_if.sv
// Handshake interfaces for the measurement and estimate channels.
// Depends on nothing.
`timescale 1ns / 1ps

interface pkf_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_z;
  logic signed [31:0] meas_roll;
  logic signed [31:0] meas_pitch;
  logic signed [31:0] meas_yaw;

  modport source (output valid, meas_x, meas_y, meas_z, meas_roll, meas_pitch, meas_yaw,
                  input ready);
  modport sink (input valid, meas_x, meas_y, meas_z, meas_roll, meas_pitch, meas_yaw,
                output ready);
endinterface

interface pkf_est_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] est_x;
  logic signed [31:0] est_y;
  logic signed [31:0] est_z;
  logic signed [31:0] est_roll;
  logic signed [31:0] est_pitch;
  logic signed [31:0] est_yaw;

  modport source (output valid, est_x, est_y, est_z, est_roll, est_pitch, est_yaw,
                  input ready);
  modport sink (input valid, est_x, est_y, est_z, est_roll, est_pitch, est_yaw,
                output ready);
endinterface

### design/pkf_ctrl.sv
// Controller for the pose Kalman filter: walks the lanes and the division
// steps and owns the input ready and output valid. Depends on pkf_pkg.
`timescale 1ns / 1ps

module pkf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pkf_pkg::pkf_cmd_t cmd_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e                      state_q;
  logic [pkf_pkg::LANE_W-1:0]  lane_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        out_valid_q;
  logic                        accept;
  logic                        publish;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign publish     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o          = '0;
    cmd_o.lane     = lane_q;
    cmd_o.capture  = accept;
    cmd_o.load     = (state_q == ST_LOAD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.upd      = (state_q == ST_UPD);
    cmd_o.publish  = publish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            lane_q  <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(FRAC_BITS)) begin
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if (lane_q == pkf_pkg::LANE_W'(pkf_pkg::DIMS - 1)) begin
            state_q <= ST_DONE;
          end else begin
            lane_q  <= lane_q + 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (publish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/pkf_datapath.sv
// Datapath for the pose Kalman filter: lane state, noise registers, the
// shared restoring divider, the two gain multipliers and the output word.
// Depends on pkf_pkg.
`timescale 1ns / 1ps

module pkf_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  pkf_pkg::pkf_cmd_t                             cmd_i,
  input  logic                                          cfg_we_i,
  input  logic [pkf_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [pkf_pkg::CFG_W-1:0]                     cfg_wdata_i,
  input  logic [pkf_pkg::DIMS-1:0][pkf_pkg::WORD_W-1:0] meas_i,
  output logic [pkf_pkg::DIMS-1:0][pkf_pkg::WORD_W-1:0] est_o
);

  localparam int QW = FRAC_BITS + 1;          // gain width, 0 .. 2^F
  localparam int PE = QW + 34;                // gain times difference
  localparam int PV = QW + 32;                // gain times prior
  localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;
  localparam logic [pkf_pkg::CFG_W-1:0] PN_RESET =
    pkf_pkg::CFG_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [pkf_pkg::CFG_W-1:0] MN_RESET =
    pkf_pkg::CFG_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  logic [pkf_pkg::CFG_W-1:0]   pn_q, mn_q;
  logic signed [31:0]          est_q [pkf_pkg::DIMS];
  logic [31:0]                 var_q [pkf_pkg::DIMS];
  logic [31:0]                 meas_q [pkf_pkg::DIMS];
  logic [pkf_pkg::DIMS-1:0][31:0] res_q;

  logic [31:0]                 prior_q;
  logic [32:0]                 denom_q;
  logic signed [32:0]          diff_q;
  logic signed [31:0]          est_old_q;
  logic [33:0]                 rem_q;
  logic [QW-1:0]               quot_q;
  logic signed [PE-1:0]        prod_e_q;
  logic [PV-1:0]               prod_v_q;

  logic signed [31:0] est_sel;
  logic [31:0]        var_sel, meas_sel, prior, var_new;
  logic [32:0]        sum, denom;
  logic signed [32:0] diff;
  logic               ge;
  logic [33:0]        rem_sub;
  logic [QW-1:0]      gain;
  logic signed [PE-1:0] corr, est_ext, est_sum;
  logic [PV-1:0]      dec;
  logic [31:0]        est_new;
  logic               ovf;

  always_comb begin
    est_sel  = est_q[cmd_i.lane];
    var_sel  = var_q[cmd_i.lane];
    meas_sel = meas_q[cmd_i.lane];
    // Prior saturates at the all-ones value.
    sum      = {1'b0, var_sel} + {2'b00, pn_q};
    prior    = sum[32] ? '1 : sum[31:0];
    denom    = {1'b0, prior} + {2'b00, mn_q};
    diff     = $signed({meas_sel[31], meas_sel}) - $signed({est_sel[31], est_sel});

    ge       = (rem_q >= {1'b0, denom_q});
    rem_sub  = ge ? (rem_q - {1'b0, denom_q}) : rem_q;

    // Zero denominator means zero prior and zero noise: keep the estimate.
    gain     = (denom_q == '0) ? '0 : quot_q;

    corr     = prod_e_q >>> FRAC_BITS;
    est_ext  = PE'(est_old_q);
    est_sum  = est_ext + corr;
    ovf      = (est_sum[PE-1:31] != {(PE - 31){est_sum[PE-1]}});
    est_new  = ovf ? (est_sum[PE-1] ? 32'h8000_0000 : 32'h7fff_ffff) : est_sum[31:0];
    dec      = prod_v_q >> FRAC_BITS;
    var_new  = prior_q - dec[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= PN_RESET;
      mn_q <= MN_RESET;
      for (int i = 0; i < pkf_pkg::DIMS; i++) begin
        est_q[i] <= '0;
        var_q[i] <= ONE_FX;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pkf_pkg::CFG_PROC_NOISE: pn_q <= cfg_wdata_i;
          pkf_pkg::CFG_MEAS_NOISE: mn_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.upd) begin
        est_q[cmd_i.lane] <= est_new;
        var_q[cmd_i.lane] <= var_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < pkf_pkg::DIMS; i++) begin
        meas_q[i] <= meas_i[i];
      end
    end
    if (cmd_i.load) begin
      prior_q   <= prior;
      denom_q   <= denom;
      diff_q    <= diff;
      est_old_q <= est_sel;
      rem_q     <= {2'b00, prior};
      quot_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[32:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_e_q <= PE'($signed({1'b0, gain})) * PE'(diff_q);
      prod_v_q <= PV'(gain) * PV'(prior_q);
    end
    if (cmd_i.publish) begin
      for (int i = 0; i < pkf_pkg::DIMS; i++) begin
        res_q[i] <= est_q[i];
      end
    end
  end

  assign est_o = res_q;

endmodule

### design/pose_kalman_filter.sv
// Top level of the pose Kalman filter: a controller and a datapath behind
// two handshake channels and a write-only configuration port.
// Depends on pkf_pkg, pkf_if, pkf_ctrl and pkf_datapath.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Word
// meas_i    in   valid / ready      meas_x .. meas_yaw, signed Q16.16
// est_o     out  valid / ready      est_x .. est_yaw, signed Q16.16
// cfg       in   cfg_we_i           cfg_idx_i selects, cfg_wdata_i 31 bits
//
// Each lane steps through prior and denominator, the shared one-bit-per-cycle gain divider,
// the multipliers and the write back, in that order.
// A word is taken only while the block is idle, once the previous estimates are published;
// the block cannot take a new word before it is through with the last one.
// Reset sets estimates to zero, variances to one and the noise registers to 0.01 and 0.1.
// A stalled output holds its word while the next one is taken; only the final copy waits.

module pose_kalman_filter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pkf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pkf_pkg::CFG_W-1:0]        cfg_wdata_i,
  pkf_meas_if.sink                         meas_i,
  pkf_est_if.source                        est_o
);

  pkf_pkg::pkf_cmd_t                              cmd;
  logic [pkf_pkg::DIMS-1:0][pkf_pkg::WORD_W-1:0]  meas_vec;
  logic [pkf_pkg::DIMS-1:0][pkf_pkg::WORD_W-1:0]  est_vec;

  // Lane order follows the field order: x, y, z, roll, pitch, yaw.
  assign meas_vec[0] = meas_i.meas_x;
  assign meas_vec[1] = meas_i.meas_y;
  assign meas_vec[2] = meas_i.meas_z;
  assign meas_vec[3] = meas_i.meas_roll;
  assign meas_vec[4] = meas_i.meas_pitch;
  assign meas_vec[5] = meas_i.meas_yaw;

  assign est_o.est_x     = est_vec[0];
  assign est_o.est_y     = est_vec[1];
  assign est_o.est_z     = est_vec[2];
  assign est_o.est_roll  = est_vec[3];
  assign est_o.est_pitch = est_vec[4];
  assign est_o.est_yaw   = est_vec[5];

  pkf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (meas_i.valid),
    .in_ready_o  (meas_i.ready),
    .out_valid_o (est_o.valid),
    .out_ready_i (est_o.ready),
    .cmd_o       (cmd)
  );

  pkf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_i      (meas_vec),
    .est_o       (est_vec)
  );

endmodule

### dv/tb_pose_kalman_filter.sv
// Self-checking testbench for pose_kalman_filter: a directed table, then random
// pose words checked against a behavioral six-lane filter held in the bench.
// Depends on pkf_pkg, pkf_if and the pose_kalman_filter RTL.
`timescale 1ns / 1ps

module tb_pose_kalman_filter;

  localparam int FRAC = 16;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 8;

  // Write indexes that decode to no register; writes there must be dropped.
  localparam logic [pkf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [pkf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // Noise register values: the reset defaults (0.01 and 0.1) and the largest one.
  localparam logic [pkf_pkg::CFG_W-1:0] PN_DEFAULT = 31'd655;
  localparam logic [pkf_pkg::CFG_W-1:0] MN_DEFAULT = 31'd6554;
  localparam logic [pkf_pkg::CFG_W-1:0] NOISE_MAX = 31'h7FFF_FFFF;

  localparam logic [63:0] GAIN_ONE = 64'd1 << FRAC;
  localparam longint EST_MAX = 64'sd2147483647;
  localparam longint EST_MIN = -64'sd2147483648;

  // Random part: a number of phases, each with its own noise setting.
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 193;

  // The receiver holds off once for a long stretch after this many words.
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 600;

  // The stall and tail limits are taken well above the time that one word takes through the block.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 50;

  // One pose: lane 0 is x, then y, z, roll, pitch and yaw.
  typedef logic [0:pkf_pkg::DIMS-1][pkf_pkg::WORD_W-1:0] pose_t;

  typedef enum logic [1:0] {
    ROW_CFG,      // register write, issued once the block has gone idle
    ROW_CHECKED,  // measurement word, expected estimate from the predictor
    ROW_TYPED     // measurement word, expected estimate written in the table
  } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [pkf_pkg::CFG_IDX_W-1:0]  idx;
    logic [pkf_pkg::CFG_W-1:0]      data;
    pose_t                          meas;
    pose_t                          want;
  } stim_row_t;

  // Directed poses. M1 and M2 put opposite extremes in the same lane, so a
  // full-gain update moves an estimate across the whole signed range.
  localparam pose_t NO_POSE = '0;
  localparam pose_t POSE_M1 = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                               32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555};
  localparam pose_t POSE_M2 = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               32'h0000_0000, 32'hAAAA_AAAA, 32'h8000_0000};
  localparam pose_t POSE_B  = {32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h1234_5678, 32'hEDCB_A988};
  localparam pose_t POSE_S  = {32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
                               32'hFFFF_FFFE, 32'h0000_8000, 32'hFFFF_8000};

  localparam int DIR_ROWS = 29;

  // Directed table. With both noise registers at zero the first word takes
  // full gain and collapses the variance to zero; after that the denominator
  // is zero, the gain is zero and the estimate is held. Raising only the
  // process noise brings back full gain. The writes to the spare indexes
  // must leave the measurement noise at zero, which the row after them shows.
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      NO_POSE, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_B,  NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_PROC_NOISE, 31'd0,      NO_POSE, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_MEAS_NOISE, 31'd0,      NO_POSE, NO_POSE},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M1, POSE_M1},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, POSE_M1},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      NO_POSE, POSE_M1},
    '{ROW_CFG,     pkf_pkg::CFG_PROC_NOISE, NOISE_MAX,  NO_POSE, NO_POSE},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, POSE_M2},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M1, POSE_M1},
    '{ROW_CFG,     CFG_SPARE_A,             31'h1234,   NO_POSE, NO_POSE},
    '{ROW_CFG,     CFG_SPARE_B,             NOISE_MAX,  NO_POSE, NO_POSE},
    '{ROW_TYPED,   pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, POSE_M2},
    '{ROW_CFG,     pkf_pkg::CFG_MEAS_NOISE, NOISE_MAX,  NO_POSE, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M1, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M1, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_PROC_NOISE, 31'd0,      NO_POSE, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      NO_POSE, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M1, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_PROC_NOISE, 31'd1,      NO_POSE, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_MEAS_NOISE, 31'd1,      NO_POSE, NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_S,  NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_B,  NO_POSE},
    '{ROW_CHECKED, pkf_pkg::CFG_PROC_NOISE, 31'd0,      POSE_M2, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_PROC_NOISE, PN_DEFAULT, NO_POSE, NO_POSE},
    '{ROW_CFG,     pkf_pkg::CFG_MEAS_NOISE, MN_DEFAULT, NO_POSE, NO_POSE}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [pkf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [pkf_pkg::CFG_W-1:0]     cfg_wdata_i;

  pkf_meas_if meas_ch ();
  pkf_est_if  est_ch ();

  pose_kalman_filter #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .meas_i     (meas_ch),
    .est_o      (est_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Bench copy of the filter state and of the noise registers.
  logic signed [pkf_pkg::WORD_W-1:0] lane_est [pkf_pkg::DIMS];
  logic [pkf_pkg::WORD_W-1:0]        lane_var [pkf_pkg::DIMS];
  logic [pkf_pkg::CFG_W-1:0]         proc_noise;
  logic [pkf_pkg::CFG_W-1:0]         meas_noise;

  // Estimates still owed by the block, oldest first.
  pose_t expected_est [$];

  int  n_err = 0;
  int  words_out = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  bit  hold_done = 1'b0;
  bit  gaps_on = 1'b1;

  // One filter update on every lane: predict the variance, form the gain,
  // move the estimate by the floored correction and shrink the variance.
  // The returned pose is the new estimate, which is what the block sends.
  function automatic pose_t filter_step(input pose_t z);
    pose_t       upd;
    logic [32:0] prior;
    logic [32:0] denom;
    logic [63:0] gain;
    logic [63:0] shrink;
    longint      diff;
    longint      corr;
    longint      nxt;
    int          i;
    for (i = 0; i < pkf_pkg::DIMS; i++) begin
      prior = {1'b0, lane_var[i]} + {2'b0, proc_noise};
      if (prior[32]) begin
        prior = 33'h0_FFFF_FFFF;
      end
      denom = prior + {2'b0, meas_noise};
      // Both noise terms at zero with a zero variance: no gain at all.
      if (denom == '0) begin
        gain = '0;
      end else begin
        gain = ({31'b0, prior} << FRAC) / {31'b0, denom};
      end
      if (gain > GAIN_ONE) begin
        gain = GAIN_ONE;
      end
      diff = longint'($signed(z[i])) - longint'(lane_est[i]);
      // Arithmetic shift floors toward minus infinity, as the block must.
      corr = (longint'(gain) * diff) >>> FRAC;
      nxt = longint'(lane_est[i]) + corr;
      if (nxt > EST_MAX) begin
        nxt = EST_MAX;
      end
      if (nxt < EST_MIN) begin
        nxt = EST_MIN;
      end
      lane_est[i] = nxt[31:0];
      shrink = (gain * {31'b0, prior}) >> FRAC;
      lane_var[i] = prior[31:0] - shrink[31:0];
      upd[i] = lane_est[i];
    end
    return upd;
  endfunction

  // Random measurement for one lane: wide values, noise around the last
  // value of the lane, values near zero and the corners of the range.
  function automatic logic [pkf_pkg::WORD_W-1:0] pick_meas(
    input logic [pkf_pkg::WORD_W-1:0] prev);
    logic signed [pkf_pkg::WORD_W-1:0] noise;
    noise = $signed($urandom) >>> $urandom_range(6, 30);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return prev + noise;
      7: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      default: return noise;
    endcase
  endfunction

  // Noise setting for one phase: zero, one, the default, the largest value,
  // or a random one, mostly small so that the gain moves between its ends.
  function automatic logic [pkf_pkg::CFG_W-1:0] pick_noise(
    input logic [pkf_pkg::CFG_W-1:0] dflt);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NOISE_MAX;
      2:       return 31'd1;
      3:       return dflt;
      4, 5:    return 31'($urandom_range(0, 1 << 20));
      6:       return 31'($urandom_range(0, 1 << 26));
      default: return 31'($urandom);
    endcase
  endfunction

  // Register write; the bench copy follows, and unknown indexes change nothing.
  task automatic write_reg(input logic [pkf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pkf_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pkf_pkg::CFG_PROC_NOISE) begin
      proc_noise = val;
    end else if (idx == pkf_pkg::CFG_MEAS_NOISE) begin
      meas_noise = val;
    end
    @(posedge clk_i);
  endtask

  // Stop offering words and wait until every estimate owed has come back.
  task automatic drain_results();
    meas_ch.valid <= 1'b0;
    while (expected_est.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offer one measurement word and hold it until the block takes it. Valid
  // stays high after acceptance unless the next call idles first, so words can
  // follow back to back from the sender. Gaps are chained bursts, which lets
  // the rise of valid land anywhere in the block's per-word schedule.
  task automatic send_pose(input pose_t z, input bit typed, input pose_t want);
    pose_t predicted;
    int    bursts;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      meas_ch.valid <= 1'b0;
      bursts = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 1;
      repeat (bursts) begin
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    meas_ch.valid      <= 1'b1;
    meas_ch.meas_x     <= z[0];
    meas_ch.meas_y     <= z[1];
    meas_ch.meas_z     <= z[2];
    meas_ch.meas_roll  <= z[3];
    meas_ch.meas_pitch <= z[4];
    meas_ch.meas_yaw   <= z[5];
    @(posedge clk_i);
    while (!meas_ch.ready) begin
      @(posedge clk_i);
    end
    predicted = filter_step(z);
    expected_est.push_back(typed ? want : predicted);
  endtask

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    pose_t prev_pose;
    pose_t z;
    int    r;
    int    ph;
    int    n;
    int    l;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= pkf_pkg::CFG_PROC_NOISE;
    cfg_wdata_i        <= '0;
    meas_ch.valid      <= 1'b0;
    meas_ch.meas_x     <= '0;
    meas_ch.meas_y     <= '0;
    meas_ch.meas_z     <= '0;
    meas_ch.meas_roll  <= '0;
    meas_ch.meas_pitch <= '0;
    meas_ch.meas_yaw   <= '0;
    for (l = 0; l < pkf_pkg::DIMS; l++) begin
      lane_est[l] = '0;
      lane_var[l] = GAIN_ONE[31:0];
    end
    proc_noise = PN_DEFAULT;
    meas_noise = MN_DEFAULT;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tab[r].idx, dir_tab[r].data);
      end else begin
        send_pose(dir_tab[r].meas, dir_tab[r].kind == ROW_TYPED, dir_tab[r].want);
      end
    end

    // Every phase boundary is also a full pause of the sender: it waits
    // for the last estimate before the noise registers change.
    prev_pose = POSE_M2;
    for (ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph != PHASES - 1) && (ph % 4 != 2);
      drain_results();
      if (ph > 0) begin
        write_reg(pkf_pkg::CFG_PROC_NOISE, pick_noise(PN_DEFAULT));
        write_reg(pkf_pkg::CFG_MEAS_NOISE, pick_noise(MN_DEFAULT));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 31'($urandom));
      end
      for (n = 0; n < PHASE_WORDS; n++) begin
        for (l = 0; l < pkf_pkg::DIMS; l++) begin
          z[l] = pick_meas(prev_pose[l]);
        end
        send_pose(z, 1'b0, NO_POSE);
        prev_pose = z;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_err == 0) begin
      $display("[pose_kalman_filter] OK");
    end else begin
      $display("[pose_kalman_filter] ERROR");
    end
    $finish;
  end

  // Estimate channel: check each word against the oldest expectation, then
  // choose ready for the next cycle. The long hold-off lets the block fill
  // up and push back on the measurement channel.
  always @(posedge clk_i) begin
    pose_t seen;
    pose_t want;
    int    bad_lanes;
    int    i;
    if (rst_ni) begin
      if (est_ch.valid && est_ch.ready) begin
        seen = {est_ch.est_x, est_ch.est_y, est_ch.est_z,
                est_ch.est_roll, est_ch.est_pitch, est_ch.est_yaw};
        if (expected_est.size() == 0) begin
          if (n_err < MAX_REPORTS) begin
            $display("%0t: estimate word with none expected: %h", $time, seen);
          end
          n_err++;
        end else begin
          want = expected_est.pop_front();
          bad_lanes = 0;
          for (i = 0; i < pkf_pkg::DIMS; i++) begin
            if (seen[i] !== want[i]) begin
              bad_lanes++;
            end
          end
          if (bad_lanes != 0) begin
            if (n_err < MAX_REPORTS) begin
              $write("%0t: %0d lane(s) wrong, expected x=%h y=%h z=%h roll=%h pitch=%h yaw=%h,",
                     $time, bad_lanes, want[0], want[1], want[2], want[3], want[4],
                     want[5]);
              $display(" got x=%h y=%h z=%h roll=%h pitch=%h yaw=%h",
                       seen[0], seen[1], seen[2], seen[3], seen[4], seen[5]);
            end
            n_err++;
          end
        end
        words_out++;
      end

      if (!hold_done && words_out >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        est_ch.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        est_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 4);
        est_ch.ready <= 1'b0;
      end else begin
        est_ch.ready <= 1'b1;
      end
    end else begin
      est_ch.ready <= 1'b0;
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((meas_ch.valid && meas_ch.ready) || (est_ch.valid && est_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d estimate(s) outstanding",
                 $time, idle_cycles, expected_est.size());
        $display("[pose_kalman_filter] ERROR");
        $finish;
      end
    end
  end

endmodule
